// ===== rtl/tpms_pkg.sv =====
// shared constants, types and helpers for the thermal plant step unit
`default_nettype none
package tpms_pkg;

  // register indexes of the configuration channel, the last two are unused
  typedef enum logic [2:0] {
    REG_MODE, REG_COEF_A, REG_COEF_B, REG_COEF_C,
    REG_COEF_D, REG_INIT_TEMP, REG_SPARE_LO, REG_SPARE_HI
  } reg_idx_e;

  // angle format of the sine path: 30 fraction bits
  localparam int ANG_FRAC = 30;
  localparam int ANG_W    = 35;

  localparam logic [32:0] TWO_PI_A      = 33'd6746518852;
  localparam logic [31:0] PI_A          = 32'd3373259426;
  localparam logic [30:0] HALF_PI_A     = 31'd1686629713;
  localparam logic [29:0] CORDIC_GAIN_A = 30'd652032874;

  // clamp for the magnitude of each rounded product before it is accumulated
  localparam logic [60:0] SQ_LIMIT = 61'h1000_0000_0000_0000;

  // multiplier bits consumed, one per cycle
  localparam int MUL_STEPS = 32;

  localparam int ATAN_N = 24;
  localparam logic [29:0] ATAN_TAB [ATAN_N] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
    30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
    30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
    30'd262144,    30'd131072,    30'd65536,     30'd32768,
    30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128
  };

  // magnitude of a two's complement word
  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tpms_mul.sv =====
// bit-serial unsigned shift-and-add multiplier, one multiplier bit per cycle
`default_nettype none
module tpms_mul #(
  parameter int MW = 47
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [31:0]         mplier_i,
  input  wire logic [MW-1:0]       mcand_i,
  output logic      [MW+31:0]      product_o,
  output logic                     done_o
);
  import tpms_pkg::*;

  logic [MW-1:0] mcand_q;
  logic [MW-1:0] acc_q;
  logic [31:0]   lo_q;
  logic [4:0]    cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [MW:0]   sum;

  // partial product add for the current multiplier bit
  assign sum = {1'b0, acc_q} + (lo_q[0] ? {1'b0, mcand_q} : {(MW+1){1'b0}});

  // shift register datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == 5'(MUL_STEPS - 1));
      if (start_i) begin
        mcand_q <= mcand_i;
        acc_q   <= '0;
        lo_q    <= mplier_i;
        cnt_q   <= '0;
        busy_q  <= 1'b1;
      end else if (busy_q) begin
        acc_q <= sum[MW:1];
        lo_q  <= {sum[0], lo_q[31:1]};
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(MUL_STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign product_o = {acc_q, lo_q};
  assign done_o    = done_q;

endmodule
`default_nettype wire

// ===== rtl/tpms_sine.sv =====
// sine of a fixed point heat sample: serial range reduction then cordic rotation
`default_nettype none
module tpms_sine #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_ITERS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] heat_i,
  output logic      [31:0] sine_o,
  output logic             done_o
);
  import tpms_pkg::*;

  localparam int RMW       = 62 - FRAC_BITS;
  localparam int RED_STEPS = 30 - FRAC_BITS;
  localparam int KW        = $clog2(RED_STEPS);
  localparam int IW        = $clog2(CORDIC_ITERS);
  localparam int ASH       = ANG_FRAC - FRAC_BITS;
  localparam int AW        = ANG_W;

  localparam logic signed [AW-1:0] TWO_PI_S = AW'(TWO_PI_A);
  localparam logic signed [AW-1:0] PI_S     = AW'(PI_A);
  localparam logic signed [AW-1:0] HALF_S   = AW'(HALF_PI_A);
  localparam logic signed [AW-1:0] ONE_S    = AW'(1) << ANG_FRAC;

  typedef enum logic [2:0] {
    S_IDLE, S_RED, S_WRAP, S_CENTRE, S_FOLD, S_ROT, S_OUT
  } state_e;

  state_e                state_q;
  logic [RMW-1:0]        mag_q;
  logic [RMW-1:0]        div_q;
  logic                  neg_q;
  logic [KW-1:0]         kcnt_q;
  logic signed [AW-1:0]  z_q;
  logic signed [AW-1:0]  x_q;
  logic signed [AW-1:0]  y_q;
  logic [IW-1:0]         it_q;
  logic [31:0]           sine_q;
  logic                  done_q;

  logic [RMW:0]          diff;
  logic [32:0]           wrap_m;
  logic signed [AW-1:0]  xs;
  logic signed [AW-1:0]  ys;
  logic signed [AW-1:0]  at;
  logic signed [AW-1:0]  yc;

  // restoring reduction step, wrap of negative samples, cordic shifts and result clamp
  always_comb begin
    diff   = {1'b0, mag_q} - {1'b0, div_q};
    wrap_m = (neg_q && (mag_q[32:0] != 33'd0)) ? (TWO_PI_A - mag_q[32:0]) : mag_q[32:0];
    xs     = x_q >>> it_q;
    ys     = y_q >>> it_q;
    at     = AW'(ATAN_TAB[5'(it_q)]);
    if (y_q > ONE_S) begin
      yc = ONE_S;
    end else if (y_q < -ONE_S) begin
      yc = -ONE_S;
    end else begin
      yc = y_q;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == S_OUT);
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            mag_q   <= RMW'(abs32(heat_i)) << ASH;
            div_q   <= RMW'(TWO_PI_A) << (RED_STEPS - 1);
            neg_q   <= heat_i[31];
            kcnt_q  <= KW'(RED_STEPS - 1);
            state_q <= S_RED;
          end
        end
        S_RED: begin
          if (!diff[RMW]) begin
            mag_q <= diff[RMW-1:0];
          end
          div_q  <= div_q >> 1;
          kcnt_q <= kcnt_q - KW'(1);
          if (kcnt_q == '0) begin
            state_q <= S_WRAP;
          end
        end
        S_WRAP: begin
          z_q     <= AW'(wrap_m);
          state_q <= S_CENTRE;
        end
        S_CENTRE: begin
          if (z_q > PI_S) begin
            z_q <= z_q - TWO_PI_S;
          end
          state_q <= S_FOLD;
        end
        S_FOLD: begin
          if (z_q > HALF_S) begin
            z_q <= PI_S - z_q;
          end else if (z_q < -HALF_S) begin
            z_q <= -PI_S - z_q;
          end
          x_q     <= AW'(CORDIC_GAIN_A);
          y_q     <= '0;
          it_q    <= '0;
          state_q <= S_ROT;
        end
        S_ROT: begin
          if (!z_q[AW-1]) begin
            x_q <= x_q - ys;
            y_q <= y_q + xs;
            z_q <= z_q - at;
          end else begin
            x_q <= x_q + ys;
            y_q <= y_q - xs;
            z_q <= z_q + at;
          end
          it_q <= it_q + IW'(1);
          if (it_q == IW'(CORDIC_ITERS - 1)) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          sine_q  <= 32'(yc >>> ASH);
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign sine_o = sine_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== rtl/thermal_plant_model_step_unit.sv =====
// thermal plant step unit: linear or nonlinear first-order temperature update
//
// input channel (in_valid_i / in_stall_o) carries heat_i and restart_i; a
// transfer happens when valid is high and stall is low. each input gives one
// result on the output channel (out_valid_o / out_stall_i) holding the
// temperature before and after the step and the saturation flag.
// configuration goes through cfg_valid_i / cfg_ready_o with a register index
// and data; ready is always high and writes belong to idle periods.
// all products run through one bit-serial multiplier: a load state, the
// multiplier bit steps and a finish, followed by a round state and, for all
// products but the squared temperature, an accumulate state. linear mode
// uses two products and nonlinear mode five; the load state of the sine
// product waits until the sine is ready. the sine unit (range reduction,
// CORDIC_ITERS rotations) runs alongside the first products. one item is in
// flight at a time; the next is taken while a finished result still waits.
// reset clears the temperature, the configuration registers and the output
// valid flag. a stalled receiver holds the result; the block then finishes
// its item and waits.
`default_nettype none
module thermal_plant_model_step_unit #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_ITERS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] heat_i,
  input  wire logic        restart_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      temp_prev_o,
  output logic [31:0]      temp_next_o,
  output logic             saturated_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import tpms_pkg::*;

  localparam int Y2W = 63 - FRAC_BITS;
  localparam int PW  = Y2W + 32;
  localparam int TXW = PW + 1 - FRAC_BITS;
  localparam int CW  = (TXW > 61) ? TXW : 61;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_MUL, S_POST, S_ACC, S_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_YY, OP_BY2, OP_AY, OP_CU, OP_DS, OP_BU
  } op_e;

  // configuration registers
  logic        mode_q;
  logic [31:0] a_q, b_q, c_q, d_q, init_q;

  state_e              state_q;
  op_e                 op_q;
  logic [31:0]         temp_q;
  logic [31:0]         heat_q;
  logic [Y2W-1:0]      y2_q;
  logic signed [63:0]  sum_q;
  logic [60:0]         tmag_q;
  logic                neg_q;
  logic                sub_q;
  logic                sin_ok_q;
  logic                out_valid_q;
  logic [31:0]         temp_prev_q;
  logic [31:0]         temp_next_q;
  logic                sat_q;

  logic                accept;
  logic                mul_start;
  logic                mul_done;
  logic [31:0]         mpl;
  logic [Y2W-1:0]      mcd;
  logic                neg_d;
  logic [PW-1:0]       prod;
  logic [PW:0]         madd;
  logic [CW-1:0]       tcl;
  logic [31:0]         sine;
  logic                sine_done;
  logic [63:0]         text;
  logic [31:0]         next_t;
  logic                sat_t;
  op_e                 op_nx;
  logic                op_last;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign mul_start   = (state_q == S_LOAD) && ((op_q != OP_DS) || sin_ok_q);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      a_q    <= '0;
      b_q    <= '0;
      c_q    <= '0;
      d_q    <= '0;
      init_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MODE:      mode_q <= cfg_data_i[0];
        REG_COEF_A:    a_q    <= cfg_data_i;
        REG_COEF_B:    b_q    <= cfg_data_i;
        REG_COEF_C:    c_q    <= cfg_data_i;
        REG_COEF_D:    d_q    <= cfg_data_i;
        REG_INIT_TEMP: init_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // operand selection for the current product
  always_comb begin
    unique case (op_q)
      OP_YY: begin
        mpl = abs32(temp_q); mcd = Y2W'(abs32(temp_q)); neg_d = 1'b0;
      end
      OP_BY2: begin
        mpl = abs32(b_q); mcd = y2_q; neg_d = b_q[31];
      end
      OP_AY: begin
        mpl = abs32(a_q); mcd = Y2W'(abs32(temp_q)); neg_d = a_q[31] ^ temp_q[31];
      end
      OP_CU: begin
        mpl = abs32(c_q); mcd = Y2W'(abs32(heat_q)); neg_d = c_q[31] ^ heat_q[31];
      end
      OP_DS: begin
        mpl = abs32(d_q); mcd = Y2W'(abs32(sine)); neg_d = d_q[31] ^ sine[31];
      end
      OP_BU: begin
        mpl = abs32(b_q); mcd = Y2W'(abs32(heat_q)); neg_d = b_q[31] ^ heat_q[31];
      end
      default: begin
        mpl = '0; mcd = '0; neg_d = 1'b0;
      end
    endcase
  end

  // next product in the schedule
  always_comb begin
    op_last = 1'b0;
    unique case (op_q)
      OP_YY:   op_nx = OP_BY2;
      OP_BY2:  op_nx = OP_AY;
      OP_AY:   op_nx = mode_q ? OP_CU : OP_BU;
      OP_CU:   op_nx = OP_DS;
      OP_DS:   begin op_nx = OP_DS; op_last = 1'b1; end
      OP_BU:   begin op_nx = OP_BU; op_last = 1'b1; end
      default: op_nx = OP_AY;
    endcase
  end

  // floor rounding of the signed product and clamp of its magnitude
  always_comb begin
    madd = {1'b0, prod} + (neg_q ? {{(PW+1-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}}
                                 : {(PW+1){1'b0}});
    tcl  = CW'(madd[PW:FRAC_BITS]);
    if (tcl > CW'(SQ_LIMIT)) begin
      tcl = CW'(SQ_LIMIT);
    end
    text = {3'b000, tmag_q};
  end

  // saturation to the 32-bit range
  always_comb begin
    if (sum_q > 64'sd2147483647) begin
      next_t = 32'h7fff_ffff; sat_t = 1'b1;
    end else if (sum_q < -64'sd2147483648) begin
      next_t = 32'h8000_0000; sat_t = 1'b1;
    end else begin
      next_t = sum_q[31:0]; sat_t = 1'b0;
    end
  end

  tpms_mul #(
    .MW (Y2W)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mplier_i  (mpl),
    .mcand_i   (mcd),
    .product_o (prod),
    .done_o    (mul_done)
  );

  tpms_sine #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_ITERS (CORDIC_ITERS)
  ) u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && mode_q),
    .heat_i  (heat_i),
    .sine_o  (sine),
    .done_o  (sine_done)
  );

  // step sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_AY;
      temp_q      <= '0;
      sin_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      if (sine_done && !accept) begin
        sin_ok_q <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (restart_i) begin
              temp_q <= init_q;
            end
            heat_q   <= heat_i;
            sum_q    <= '0;
            sin_ok_q <= 1'b0;
            op_q     <= mode_q ? OP_YY : OP_AY;
            state_q  <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (mul_start) begin
            neg_q   <= neg_d;
            sub_q   <= (op_q == OP_BY2);
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            state_q <= S_POST;
          end
        end
        S_POST: begin
          if (op_q == OP_YY) begin
            y2_q    <= prod[FRAC_BITS+Y2W-1:FRAC_BITS];
            op_q    <= op_nx;
            state_q <= S_LOAD;
          end else begin
            tmag_q  <= tcl[60:0];
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          sum_q <= (neg_q ^ sub_q) ? (sum_q - $signed(text)) : (sum_q + $signed(text));
          if (op_last) begin
            state_q <= S_DONE;
          end else begin
            op_q    <= op_nx;
            state_q <= S_LOAD;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            temp_prev_q <= temp_q;
            temp_next_q <= next_t;
            sat_q       <= sat_t;
            out_valid_q <= 1'b1;
            temp_q      <= next_t;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign temp_prev_o = temp_prev_q;
  assign temp_next_o = temp_next_q;
  assign saturated_o = sat_q;

  // multiplier completion only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_MUL))
    else $error("multiplier finished outside the wait state");

  // the sine product is never accumulated before the sine is ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC && op_q == OP_DS) |-> sin_ok_q)
    else $error("sine term used before the sine unit finished");

  // a clipped result is one of the two range limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (temp_next_o == 32'h7fff_ffff || temp_next_o == 32'h8000_0000))
    else $error("saturation flag without a limit value");

  // a fresh result follows the finishing state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (!out_valid_q || !out_stall_i)) |=>
      (out_valid_o && state_q == S_IDLE && temp_q == temp_next_o))
    else $error("result not presented after the step finished");

endmodule
`default_nettype wire
